>>> rtl/core/sha256md_pkg.sv
// Shared types, command and status structs, and SHA-256 constants for the digest core.
package sha256md_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       last;
	} msg_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        digest_last;
	} digest_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PAD80,
		ST_ZERO,
		ST_LEN,
		ST_LOAD,
		ST_ROUND,
		ST_FOLD,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		SRC_MSG,
		SRC_PAD,
		SRC_ZERO,
		SRC_LEN
	} byte_src_t;

	typedef struct packed {
		logic       put;
		byte_src_t  src;
		logic       count_byte;
		logic       close;
		logic       load_work;
		logic       round;
		logic [5:0] round_idx;
		logic       fold;
		logic       emit;
	} dp_cmd_t;

	typedef struct packed {
		logic [5:0] fill;
		logic       out_free;
	} dp_status_t;

	localparam logic [5:0] FILL_LAST   = 6'd63;
	localparam logic [5:0] FILL_LEN_AT = 6'd56;
	localparam logic [5:0] ROUND_LAST  = 6'd63;
	localparam logic [2:0] LEN_LAST    = 3'd7;
	localparam logic [2:0] WORD_LAST   = 3'd7;
	localparam logic [7:0] PAD_BYTE    = 8'h80;

	localparam logic [31:0] INIT_CHAIN [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

endpackage

>>> rtl/core/sha256md_ctrl.sv
// Sequencing state machine: byte intake, padding, length, compression rounds and digest hand-off.
module sha256md_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     msg_valid,
	input  sha256md_pkg::msg_t       msg,
	input  sha256md_pkg::dp_status_t status,
	output logic                     ready,
	output sha256md_pkg::dp_cmd_t    cmd
);

	sha256md_pkg::state_t state_q, state_d;
	sha256md_pkg::state_t resume_q, resume_d;
	logic [5:0]           round_q;
	logic [2:0]           len_cnt_q;
	logic                 accept;
	logic                 full;

	assign accept = (state_q == sha256md_pkg::ST_IDLE) && msg_valid;
	assign full   = (status.fill == sha256md_pkg::FILL_LAST);

	always_comb begin
		state_d  = state_q;
		resume_d = resume_q;
		unique case (state_q)
			sha256md_pkg::ST_IDLE: begin
				if (accept) begin
					if (msg.byte_valid && full) begin
						state_d  = sha256md_pkg::ST_LOAD;
						resume_d = msg.last ? sha256md_pkg::ST_PAD80 : sha256md_pkg::ST_IDLE;
					end else if (msg.last) begin
						state_d = sha256md_pkg::ST_PAD80;
					end
				end
			end
			sha256md_pkg::ST_PAD80: begin
				if (full) begin
					state_d  = sha256md_pkg::ST_LOAD;
					resume_d = sha256md_pkg::ST_ZERO;
				end else begin
					state_d = sha256md_pkg::ST_ZERO;
				end
			end
			sha256md_pkg::ST_ZERO: begin
				if (status.fill == sha256md_pkg::FILL_LEN_AT) begin
					state_d = sha256md_pkg::ST_LEN;
				end else if (full) begin
					state_d  = sha256md_pkg::ST_LOAD;
					resume_d = sha256md_pkg::ST_ZERO;
				end
			end
			sha256md_pkg::ST_LEN: begin
				if (len_cnt_q == sha256md_pkg::LEN_LAST) begin
					state_d  = sha256md_pkg::ST_LOAD;
					resume_d = sha256md_pkg::ST_EMIT;
				end
			end
			sha256md_pkg::ST_LOAD: begin
				state_d = sha256md_pkg::ST_ROUND;
			end
			sha256md_pkg::ST_ROUND: begin
				if (round_q == sha256md_pkg::ROUND_LAST) begin
					state_d = sha256md_pkg::ST_FOLD;
				end
			end
			sha256md_pkg::ST_FOLD: begin
				state_d = resume_q;
			end
			sha256md_pkg::ST_EMIT: begin
				if (status.out_free) begin
					state_d = sha256md_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sha256md_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ready          = 1'b0;
		cmd.put        = 1'b0;
		cmd.src        = sha256md_pkg::SRC_MSG;
		cmd.count_byte = 1'b0;
		cmd.close      = 1'b0;
		cmd.load_work  = 1'b0;
		cmd.round      = 1'b0;
		cmd.round_idx  = round_q;
		cmd.fold       = 1'b0;
		cmd.emit       = 1'b0;
		unique case (state_q)
			sha256md_pkg::ST_IDLE: begin
				ready          = 1'b1;
				cmd.put        = accept && msg.byte_valid;
				cmd.count_byte = accept && msg.byte_valid;
				cmd.close      = accept && msg.last;
			end
			sha256md_pkg::ST_PAD80: begin
				cmd.put = 1'b1;
				cmd.src = sha256md_pkg::SRC_PAD;
			end
			sha256md_pkg::ST_ZERO: begin
				cmd.put = (status.fill != sha256md_pkg::FILL_LEN_AT);
				cmd.src = sha256md_pkg::SRC_ZERO;
			end
			sha256md_pkg::ST_LEN: begin
				cmd.put = 1'b1;
				cmd.src = sha256md_pkg::SRC_LEN;
			end
			sha256md_pkg::ST_LOAD: begin
				cmd.load_work = 1'b1;
			end
			sha256md_pkg::ST_ROUND: begin
				cmd.round = 1'b1;
			end
			sha256md_pkg::ST_FOLD: begin
				cmd.fold = 1'b1;
			end
			sha256md_pkg::ST_EMIT: begin
				cmd.emit = status.out_free;
			end
			default: begin
				ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= sha256md_pkg::ST_IDLE;
			resume_q  <= sha256md_pkg::ST_IDLE;
			round_q   <= '0;
			len_cnt_q <= '0;
		end else begin
			state_q  <= state_d;
			resume_q <= resume_d;
			if (state_q == sha256md_pkg::ST_LOAD) begin
				round_q <= '0;
			end else if (state_q == sha256md_pkg::ST_ROUND) begin
				round_q <= round_q + 6'd1;
			end
			if (state_q == sha256md_pkg::ST_LEN) begin
				len_cnt_q <= len_cnt_q + 3'd1;
			end else begin
				len_cnt_q <= '0;
			end
		end
	end

endmodule

>>> rtl/core/sha256md_datapath.sv
// Block buffer and schedule window, round unit, chaining words, length count and digest buffer.
module sha256md_datapath (
	input  logic                     clk,
	input  logic                     arst_n,
	input  sha256md_pkg::dp_cmd_t    cmd,
	input  logic [7:0]               data_byte,
	input  logic                     digest_stall,
	output sha256md_pkg::dp_status_t status,
	output logic                     digest_valid,
	output sha256md_pkg::digest_t    digest
);

	function automatic logic [31:0] ror(input logic [31:0] v, input int unsigned n);
		ror = (v >> n) | (v << (32 - n));
	endfunction

	logic [31:0]  chain_q [8];
	logic [31:0]  work_q  [8];
	logic [31:0]  dig_q   [8];
	logic [511:0] win_q;
	logic [5:0]   fill_q;
	logic [63:0]  msg_bits_q;
	logic [63:0]  len_q;
	logic [3:0]   out_cnt_q;
	logic [2:0]   idx_q;
	logic [7:0]   put_byte;
	logic [31:0]  w0, w1, w9, w14, w_next;
	logic [31:0]  big0, big1, choose, major, t1, t2;
	logic         out_take;

	always_comb begin
		unique case (cmd.src)
			sha256md_pkg::SRC_MSG:  put_byte = data_byte;
			sha256md_pkg::SRC_PAD:  put_byte = sha256md_pkg::PAD_BYTE;
			sha256md_pkg::SRC_ZERO: put_byte = 8'h00;
			sha256md_pkg::SRC_LEN:  put_byte = len_q[63:56];
			default:                put_byte = 8'h00;
		endcase
	end

	// window word j sits at bits 511-32j down; word 0 is the current round's word
	assign w0  = win_q[511:480];
	assign w1  = win_q[479:448];
	assign w9  = win_q[223:192];
	assign w14 = win_q[63:32];
	assign w_next = (ror(w14, 17) ^ ror(w14, 19) ^ (w14 >> 10)) + w9
		+ (ror(w1, 7) ^ ror(w1, 18) ^ (w1 >> 3)) + w0;

	assign big1   = ror(work_q[4], 6) ^ ror(work_q[4], 11) ^ ror(work_q[4], 25);
	assign choose = (work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]);
	assign t1     = work_q[7] + big1 + choose + sha256md_pkg::ROUND_K[cmd.round_idx] + w0;
	assign big0   = ror(work_q[0], 2) ^ ror(work_q[0], 13) ^ ror(work_q[0], 22);
	assign major  = (work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2])
		^ (work_q[1] & work_q[2]);
	assign t2     = big0 + major;

	assign out_take = digest_valid && !digest_stall;

	// control state and defined-reset stores
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= sha256md_pkg::INIT_CHAIN[i];
			end
			fill_q     <= '0;
			msg_bits_q <= '0;
			out_cnt_q  <= '0;
			idx_q      <= '0;
		end else begin
			if (cmd.put) begin
				fill_q <= fill_q + 6'd1;
			end
			if (cmd.close) begin
				msg_bits_q <= '0;
			end else if (cmd.count_byte) begin
				msg_bits_q <= msg_bits_q + 64'd8;
			end
			if (cmd.fold) begin
				for (int i = 0; i < 8; i++) begin
					chain_q[i] <= chain_q[i] + work_q[i];
				end
			end else if (cmd.emit) begin
				for (int i = 0; i < 8; i++) begin
					chain_q[i] <= sha256md_pkg::INIT_CHAIN[i];
				end
			end
			if (cmd.emit) begin
				out_cnt_q <= 4'd8;
				idx_q     <= '0;
			end else if (out_take) begin
				out_cnt_q <= out_cnt_q - 4'd1;
				idx_q     <= idx_q + 3'd1;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.put) begin
			win_q <= {win_q[503:0], put_byte};
		end else if (cmd.round) begin
			win_q <= {win_q[479:0], w_next};
		end
		if (cmd.close) begin
			len_q <= msg_bits_q + (cmd.count_byte ? 64'd8 : 64'd0);
		end else if (cmd.put && (cmd.src == sha256md_pkg::SRC_LEN)) begin
			len_q <= {len_q[55:0], 8'h00};
		end
		if (cmd.load_work) begin
			for (int i = 0; i < 8; i++) begin
				work_q[i] <= chain_q[i];
			end
		end else if (cmd.round) begin
			work_q[0] <= t1 + t2;
			work_q[1] <= work_q[0];
			work_q[2] <= work_q[1];
			work_q[3] <= work_q[2];
			work_q[4] <= work_q[3] + t1;
			work_q[5] <= work_q[4];
			work_q[6] <= work_q[5];
			work_q[7] <= work_q[6];
		end
		if (cmd.emit) begin
			for (int i = 0; i < 8; i++) begin
				dig_q[i] <= chain_q[i];
			end
		end else if (out_take) begin
			for (int i = 0; i < 7; i++) begin
				dig_q[i] <= dig_q[i + 1];
			end
		end
	end

	assign status.fill     = fill_q;
	assign status.out_free = (out_cnt_q == 4'd0);

	assign digest_valid       = (out_cnt_q != 4'd0);
	assign digest.digest_word = dig_q[0];
	assign digest.word_index  = idx_q;
	assign digest.digest_last = (idx_q == sha256md_pkg::WORD_LAST);

endmodule

>>> rtl/core/sha256_message_digest.sv
// Top level of the byte-stream SHA-256 digest core.
//
// Feed a message one byte per word on the msg channel; a word with last set
// closes the message (byte_valid low with last high closes it without adding a
// byte, which also covers the empty message). The digest comes out as eight
// 32-bit words on the digest channel, h0 first, with word_index 0 to 7 and
// digest_last on the eighth. Each completed 64-byte block then holds the input
// through the working-register load, 64 rounds through the single shared round
// unit and the chain fold. Closing a message writes the 0x80 byte, then the zero
// pad bytes one at a time with a final check for the length slot, then the eight
// length bytes, compresses the final block and hands the digest to the output
// buffer. The digest buffer drains one word a cycle, when digest_stall is low,
// as the next message streams in; the next digest hand-off waits only if the
// previous digest has not yet been fully taken.
module sha256_message_digest (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  msg_valid,
	output logic                  msg_stall,
	input  sha256md_pkg::msg_t    msg,
	output logic                  digest_valid,
	input  logic                  digest_stall,
	output sha256md_pkg::digest_t digest
);

	sha256md_pkg::dp_cmd_t    cmd;
	sha256md_pkg::dp_status_t status;
	logic                     ready;

	// hold the sender whenever the sequencer is busy padding, compressing or handing off the digest
	assign msg_stall = !ready;

	sha256md_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_valid (msg_valid),
		.msg       (msg),
		.status    (status),
		.ready     (ready),
		.cmd       (cmd)
	);

	sha256md_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.data_byte    (msg.data_byte),
		.digest_stall (digest_stall),
		.status       (status),
		.digest_valid (digest_valid),
		.digest       (digest)
	);

	// the buffer is reloaded only once empty, so the last word is always followed by a gap
	assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid && !digest_stall && digest.digest_last |=> !digest_valid)
		else $error("digest valid straight after the final word");

	// words leave in order, one index step per taken word
	assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid && !digest_stall && !digest.digest_last |=>
			digest_valid && (digest.word_index == 3'($past(digest.word_index) + 3'd1)))
		else $error("digest word index did not advance");

	// never overwrite a digest that is still draining
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> status.out_free)
		else $error("digest hand-off while output buffer busy");

	// the window either takes a byte or runs a round, never both
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.put |-> !cmd.round && !cmd.load_work && !cmd.fold)
		else $error("byte write during compression");

endmodule
